[hw/rtl/bexl_pkg.sv]
// Shared types, constants and the result record for the expression lexer.
`timescale 1ns / 1ps

package bexl_pkg;

    // Longest number text (digits and point) and longest identifier, in bytes.
    localparam int NUMBER_CHARS = 16;
    localparam int IDENT_CHARS  = 32;

    // Result queue depth; must be a power of two and at least two.
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_T      = 8'h74;

    // UTF-8 continuation bytes look like 10xxxxxx.
    localparam logic [7:0] UTF8_CONT_MASK = 8'b1100_0000;
    localparam logic [7:0] UTF8_CONT_VAL  = 8'b1000_0000;

    typedef enum logic [3:0] {
        TK_EOF    = 4'd0,
        TK_EOL    = 4'd1,
        TK_ERR    = 4'd2,
        TK_NUM    = 4'd3,
        TK_PLUS   = 4'd4,
        TK_MINUS  = 4'd5,
        TK_STAR   = 4'd6,
        TK_SLASH  = 4'd7,
        TK_LPAREN = 4'd8,
        TK_RPAREN = 4'd9,
        TK_IDENT  = 4'd10,
        TK_LET    = 4'd11,
        TK_EQUAL  = 4'd12
    } token_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_UNEXPECTED = 3'd1,
        ERR_NUM_LONG   = 3'd2,
        ERR_NUM_BAD    = 3'd3,
        ERR_IDENT_LONG = 3'd4
    } error_kind_t;

    typedef struct packed {
        token_kind_t  token_kind;
        error_kind_t  error_kind;
        logic [15:0]  line_no;
        logic [15:0]  column_no;
        logic [23:0]  start_offset;
        logic [7:0]   text_length;
        logic [53:0]  mantissa;
        logic [4:0]   fraction_digits;
        logic [7:0]   bad_byte;
        logic         last_of_run;
    } lex_res_t;

    // Up to two results per source byte, in delivery order.
    typedef struct packed {
        logic     v0;
        logic     v1;
        lex_res_t r0;
        lex_res_t r1;
    } step_out_t;

endpackage

[hw/rtl/bexl_core.sv]
// Scanner state and the per-byte next-state and token logic.
`timescale 1ns / 1ps

module bexl_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           source_byte,
    output bexl_pkg::step_out_t  results
);
    import bexl_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_COMMENT,
        PH_INT,
        PH_DOT,
        PH_FRAC,
        PH_BAD,
        PH_IDENT,
        PH_SKIP
    } phase_t;

    localparam logic [7:0] NUM_LIM   = 8'(NUMBER_CHARS);
    localparam logic [7:0] IDENT_LIM = 8'(IDENT_CHARS);

    phase_t       phase_reg,    phase_next;
    logic [15:0]  line_reg,     line_next;
    logic [15:0]  col_reg,      col_next;
    logic [23:0]  offset_reg,   offset_next;
    logic [15:0]  hline_reg,    hline_next;
    logic [15:0]  hcol_reg,     hcol_next;
    logic [23:0]  hoffset_reg,  hoffset_next;
    logic [7:0]   len_reg,      len_next;
    logic [53:0]  accum_reg,    accum_next;
    logic [4:0]   frac_reg,     frac_next;
    logic [1:0]   kwp_reg,      kwp_next;

    logic [7:0]   b;
    logic         b_digit;
    logic         b_alpha;
    logic         b_ident;
    logic [53:0]  accum_x10;

    // Start-of-token decode of the current byte.
    logic         st_emit;
    logic         st_restart;
    logic         st_init;
    phase_t       st_phase;
    lex_res_t     st_res;

    logic         held_v;
    lex_res_t     held_res;
    logic         do_start;
    logic         restart;

    function automatic logic [7:0] kw_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = CH_L;
            2'd1:    r = CH_E;
            2'd2:    r = CH_T;
            default: r = CH_NUL;
        endcase
        return r;
    endfunction

    assign b       = source_byte;
    assign b_digit = (b >= 8'h30) && (b <= 8'h39);
    assign b_alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    assign b_ident = b_alpha || b_digit || (b == CH_UNDER);

    // Times ten as two shifted copies; the digit value is the low nibble.
    assign accum_x10 = {accum_reg[50:0], 3'b000} + {accum_reg[52:0], 1'b0}
                     + {50'd0, b[3:0]};

    always_comb
    begin
        st_emit    = 1'b0;
        st_restart = 1'b0;
        st_init    = 1'b0;
        st_phase   = PH_IDLE;
        st_res     = '0;
        st_res.token_kind   = TK_EOF;
        st_res.error_kind   = ERR_NONE;
        st_res.line_no      = line_reg;
        st_res.column_no    = col_reg;
        st_res.start_offset = offset_reg;
        st_res.text_length  = 8'd1;
        case (b)
            CH_SPACE, CH_TAB: st_phase = PH_IDLE;
            CH_HASH:          st_phase = PH_COMMENT;
            CH_NUL:
            begin
                st_emit            = 1'b1;
                st_restart         = 1'b1;
                st_res.text_length = 8'd0;
            end
            CH_LF:     begin st_emit = 1'b1; st_res.token_kind = TK_EOL;    end
            CH_PLUS:   begin st_emit = 1'b1; st_res.token_kind = TK_PLUS;   end
            CH_MINUS:  begin st_emit = 1'b1; st_res.token_kind = TK_MINUS;  end
            CH_STAR:   begin st_emit = 1'b1; st_res.token_kind = TK_STAR;   end
            CH_SLASH:  begin st_emit = 1'b1; st_res.token_kind = TK_SLASH;  end
            CH_LPAREN: begin st_emit = 1'b1; st_res.token_kind = TK_LPAREN; end
            CH_RPAREN: begin st_emit = 1'b1; st_res.token_kind = TK_RPAREN; end
            CH_EQUAL:  begin st_emit = 1'b1; st_res.token_kind = TK_EQUAL;  end
            default:
            begin
                st_init = 1'b1;
                if (b_digit)
                begin
                    st_phase = PH_INT;
                end
                else if (b == CH_DOT)
                begin
                    st_phase = PH_DOT;
                end
                else if (b_alpha || (b == CH_UNDER))
                begin
                    st_phase = PH_IDENT;
                end
                else
                begin
                    st_emit           = 1'b1;
                    st_phase          = PH_SKIP;
                    st_res.token_kind = TK_ERR;
                    st_res.error_kind = ERR_UNEXPECTED;
                    st_res.bad_byte   = b;
                end
            end
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        offset_next  = offset_reg;
        hline_next   = hline_reg;
        hcol_next    = hcol_reg;
        hoffset_next = hoffset_reg;
        len_next     = len_reg;
        accum_next   = accum_reg;
        frac_next    = frac_reg;
        kwp_next     = kwp_reg;
        do_start     = 1'b0;
        restart      = 1'b0;
        held_v       = 1'b0;
        held_res     = '0;
        held_res.token_kind   = TK_ERR;
        held_res.error_kind   = ERR_NONE;
        held_res.line_no      = hline_reg;
        held_res.column_no    = hcol_reg;
        held_res.start_offset = hoffset_reg;
        held_res.text_length  = len_reg;

        case (phase_reg)
            PH_COMMENT:
            begin
                if ((b == CH_LF) || (b == CH_NUL))
                    do_start = 1'b1;
            end
            PH_INT, PH_DOT, PH_FRAC:
            begin
                if (b_digit)
                begin
                    if (len_reg >= NUM_LIM)
                    begin
                        phase_next          = PH_SKIP;
                        held_v              = 1'b1;
                        held_res.error_kind = ERR_NUM_LONG;
                    end
                    else
                    begin
                        accum_next = accum_x10;
                        len_next   = (len_reg == 8'hFF) ? len_reg : len_reg + 8'd1;
                        if (phase_reg != PH_INT)
                        begin
                            frac_next  = (frac_reg == 5'd31) ? frac_reg : frac_reg + 5'd1;
                            phase_next = PH_FRAC;
                        end
                    end
                end
                else if (phase_reg == PH_DOT)
                begin
                    // A lone point: the following byte still joins the bad text.
                    len_next   = (len_reg == 8'hFF) ? len_reg : len_reg + 8'd1;
                    phase_next = PH_BAD;
                    if (b == CH_NUL)
                    begin
                        held_v               = 1'b1;
                        held_res.error_kind  = ERR_NUM_BAD;
                        held_res.text_length = len_next;
                        restart              = 1'b1;
                    end
                end
                else if ((b == CH_DOT) && (phase_reg == PH_INT))
                begin
                    len_next   = (len_reg == 8'hFF) ? len_reg : len_reg + 8'd1;
                    phase_next = PH_DOT;
                end
                else if (b == CH_DOT)
                begin
                    // Second point after fraction digits.
                    if (len_reg >= NUM_LIM)
                    begin
                        held_v                = 1'b1;
                        held_res.error_kind   = ERR_NUM_LONG;
                        held_res.line_no      = line_reg;
                        held_res.column_no    = col_reg;
                        held_res.start_offset = offset_reg;
                        phase_next            = PH_SKIP;
                    end
                    else
                    begin
                        len_next   = (len_reg == 8'hFF) ? len_reg : len_reg + 8'd1;
                        phase_next = PH_BAD;
                    end
                end
                else
                begin
                    held_v                   = 1'b1;
                    held_res.token_kind      = TK_NUM;
                    held_res.mantissa        = accum_reg;
                    held_res.fraction_digits = frac_reg;
                    do_start                 = 1'b1;
                end
            end
            PH_BAD:
            begin
                if (b_digit && (len_reg < NUM_LIM))
                begin
                    len_next = (len_reg == 8'hFF) ? len_reg : len_reg + 8'd1;
                end
                else
                begin
                    held_v              = 1'b1;
                    held_res.error_kind = ERR_NUM_BAD;
                    phase_next          = PH_SKIP;
                    restart             = (b == CH_NUL);
                end
            end
            PH_IDENT:
            begin
                if (b_ident)
                begin
                    if (len_reg >= IDENT_LIM)
                    begin
                        held_v              = 1'b1;
                        held_res.error_kind = ERR_IDENT_LONG;
                        phase_next          = PH_SKIP;
                    end
                    else
                    begin
                        if ((len_reg < 8'd3) && ({6'd0, kwp_reg} == len_reg)
                            && (b == kw_byte(len_reg[1:0])))
                            kwp_next = kwp_reg + 2'd1;
                        len_next = (len_reg == 8'hFF) ? len_reg : len_reg + 8'd1;
                    end
                end
                else
                begin
                    held_v              = 1'b1;
                    held_res.token_kind = ((len_reg == 8'd3) && (kwp_reg == 2'd3))
                                        ? TK_LET : TK_IDENT;
                    do_start            = 1'b1;
                end
            end
            PH_SKIP:
            begin
                restart = (b == CH_NUL);
            end
            default:
            begin
                do_start = 1'b1;
            end
        endcase

        if (do_start)
        begin
            phase_next   = st_phase;
            hline_next   = line_reg;
            hcol_next    = col_reg;
            hoffset_next = offset_reg;
            if (st_init)
            begin
                accum_next = b_digit ? {50'd0, b[3:0]} : 54'd0;
                frac_next  = 5'd0;
                len_next   = 8'd1;
                kwp_next   = (b == CH_L) ? 2'd1 : 2'd0;
            end
            if (st_restart)
                restart = 1'b1;
        end

        if (restart)
        begin
            phase_next   = PH_IDLE;
            line_next    = 16'd1;
            col_next     = 16'd1;
            offset_next  = 24'd0;
            hline_next   = 16'd1;
            hcol_next    = 16'd1;
            hoffset_next = 24'd0;
            len_next     = 8'd0;
            accum_next   = 54'd0;
            frac_next    = 5'd0;
            kwp_next     = 2'd0;
        end
        else
        begin
            if (b == CH_LF)
            begin
                line_next = (line_reg == 16'hFFFF) ? line_reg : line_reg + 16'd1;
                col_next  = 16'd1;
            end
            else if ((b & UTF8_CONT_MASK) != UTF8_CONT_VAL)
            begin
                col_next = (col_reg == 16'hFFFF) ? col_reg : col_reg + 16'd1;
            end
            offset_next = (offset_reg == 24'hFF_FFFF) ? offset_reg : offset_reg + 24'd1;
        end
    end

    // Order the held token before the one that the same byte starts.
    always_comb
    begin
        logic start_v;
        start_v = do_start && st_emit;
        results = '0;
        if (held_v)
        begin
            results.v0 = step;
            results.v1 = step && start_v;
            results.r0 = held_res;
            results.r1 = st_res;
            results.r0.last_of_run = !start_v;
            results.r1.last_of_run = 1'b1;
        end
        else
        begin
            results.v0 = step && start_v;
            results.r0 = st_res;
            results.r1 = st_res;
            results.r0.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            line_reg    <= 16'd1;
            col_reg     <= 16'd1;
            offset_reg  <= 24'd0;
            hline_reg   <= 16'd1;
            hcol_reg    <= 16'd1;
            hoffset_reg <= 24'd0;
            len_reg     <= 8'd0;
            accum_reg   <= 54'd0;
            frac_reg    <= 5'd0;
            kwp_reg     <= 2'd0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            offset_reg  <= offset_next;
            hline_reg   <= hline_next;
            hcol_reg    <= hcol_next;
            hoffset_reg <= hoffset_next;
            len_reg     <= len_next;
            accum_reg   <= accum_next;
            frac_reg    <= frac_next;
            kwp_reg     <= kwp_next;
        end
    end

endmodule

[hw/rtl/bexl_fifo.sv]
// Small result queue that takes up to two words per cycle and gives one.
`timescale 1ns / 1ps

module bexl_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bexl_pkg::step_out_t                 wr,
    input  logic                                pop,
    output logic                                head_valid,
    output bexl_pkg::lex_res_t                  head,
    output logic                                room2
);
    import bexl_pkg::*;

    lex_res_t                mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]    wp_reg;
    logic [RES_PTR_W-1:0]    rp_reg;
    logic [RES_CNT_W-1:0]    count_reg;
    logic [RES_CNT_W-1:0]    count_next;
    logic                    do_pop;
    logic [RES_PTR_W-1:0]    wp_inc;

    assign head_valid = (count_reg != '0);
    assign head       = mem[rp_reg];
    assign do_pop     = pop && head_valid;
    assign room2      = (count_reg <= RES_CNT_W'(RES_DEPTH - 2));
    assign wp_inc     = wp_reg + RES_PTR_W'(1);

    always_comb
    begin
        count_next = count_reg;
        if (wr.v1)
            count_next = count_next + RES_CNT_W'(2);
        else if (wr.v0)
            count_next = count_next + RES_CNT_W'(1);
        if (do_pop)
            count_next = count_next - RES_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr.v0)
            mem[wp_reg] <= wr.r0;
        if (wr.v1)
            mem[wp_inc] <= wr.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr.v1)
                wp_reg <= wp_reg + RES_PTR_W'(2);
            else if (wr.v0)
                wp_reg <= wp_inc;
            if (do_pop)
                rp_reg <= rp_reg + RES_PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

[hw/rtl/basic_expression_lexer.sv]
// Top level of the streaming expression lexer: input register, scanner, result queue.
//
//  channel   dir  word                               tuser        tlast
//  s_axis    in   tdata[7:0] source_byte             -            -
//  m_axis    out  tdata[135:0] see port comment      token_kind   last_of_run
//
// One source byte is taken per cycle while the four-entry result queue has two
// or more free entries, and is held back otherwise. Each byte is registered at
// the input, scanned, and its results are queued. A byte that ends a number or
// an identifier and starts another token gives two words, which leave one after
// the other. A NUL byte returns line, column and offset to the start.
// rst_n clears the scanner and the queue pointers; queued payload is not reset.
`timescale 1ns / 1ps

module basic_expression_lexer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] source_byte
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [2:0] error_kind, [18:3] line_no, [34:19] column_no, [58:35] start_offset,
    // [66:59] text_length, [120:67] mantissa, [125:121] fraction_digits,
    // [133:126] bad_byte, [135:134] zero
    output logic [135:0]  m_axis_tdata,
    output logic [3:0]    m_axis_tuser,   // [3:0] token_kind
    output logic          m_axis_tlast    // last_of_run
);
    import bexl_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;
    logic        room2;
    logic        head_valid;
    lex_res_t    head;
    step_out_t   step_res;

    assign advance       = in_valid_reg && room2;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
    end

    bexl_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .source_byte (in_byte_reg),
        .results     (step_res)
    );

    bexl_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (step_res),
        .pop        (m_axis_tready),
        .head_valid (head_valid),
        .head       (head),
        .room2      (room2)
    );

    assign m_axis_tvalid = head_valid;
    assign m_axis_tuser  = head.token_kind;
    assign m_axis_tlast  = head.last_of_run;
    assign m_axis_tdata  = {2'b00, head.bad_byte, head.fraction_digits, head.mantissa,
                            head.text_length, head.start_offset, head.column_no,
                            head.line_no, head.error_kind};

    // An error word carries an error code and no other word does.
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == TK_ERR) == (m_axis_tdata[2:0] != ERR_NONE)))
        else $error("error code does not match token kind");

    // End of source has no text and no number value.
    a_eof_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == TK_EOF))
        |-> ((m_axis_tdata[66:59] == 8'd0) && (m_axis_tdata[120:67] == 54'd0)))
        else $error("end of source word carries text");

    // The first of two words from one byte never closes the run.
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        step_res.v1 |-> (step_res.v0 && !step_res.r0.last_of_run
                         && step_res.r1.last_of_run))
        else $error("two-word byte has wrong run marks");

    // Bytes are only taken into the scanner when the queue can hold two words.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        step_res.v0 |-> room2)
        else $error("result queue overflow");

endmodule
